>>> rtl/matrix3x3_inverse_assert.svh
// Assertion macros for the 3x3 matrix inverse block.
// Used by the top level only; depends on ports named clock and reset.
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define M3I_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("matrix inverse check failed");

// Next-cycle implication, disabled during reset.
`define M3I_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("matrix inverse check failed");

`endif

>>> rtl/m3i_pkg.sv
// Shared types and width constants for the 3x3 matrix inverse block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package m3i_pkg;
   localparam int ELEM_W = 32;
   localparam int PROD_W = 2 * ELEM_W;
   localparam int COF_W  = 2 * ELEM_W + 2;
   localparam int DET_W  = 3 * ELEM_W + 4;
   localparam int NUM_LANES = 9;

   typedef logic signed [ELEM_W-1:0] elem_type;

   localparam elem_type ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam elem_type ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

   typedef logic [NUM_LANES-1:0][ELEM_W-1:0] quot_vec_type;

   typedef struct packed {
      elem_type a00;
      elem_type a01;
      elem_type a02;
      elem_type a10;
      elem_type a11;
      elem_type a12;
      elem_type a20;
      elem_type a21;
      elem_type a22;
   } req_type;

   typedef struct packed {
      elem_type inv00;
      elem_type inv01;
      elem_type inv02;
      elem_type inv10;
      elem_type inv11;
      elem_type inv12;
      elem_type inv20;
      elem_type inv21;
      elem_type inv22;
      elem_type det_value;
      logic     singular;
   } rsp_type;
endpackage

>>> rtl/m3i_div_lane.sv
// One divider lane: pipelined restoring division of a scaled cofactor by the
// determinant, one quotient bit per stage, with saturation. Uses m3i_pkg.
`timescale 1ns / 1ps

module m3i_div_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [m3i_pkg::COF_W-1:0]   num,
   input  logic signed [m3i_pkg::DET_W-1:0]   den,
   output m3i_pkg::elem_type                  quot
);
   import m3i_pkg::*;

   localparam int NW = COF_W + 2 * FRAC_BITS;
   localparam int RW = ((NW > DET_W + ELEM_W) ? NW : DET_W + ELEM_W) + 1;
   localparam int NS = ELEM_W;
   localparam logic [ELEM_W:0] LIM = (ELEM_W + 1)'(1) << (ELEM_W - 1);

   logic signed [RW-1:0] num_ext;
   logic signed [RW-1:0] den_ext;
   logic [RW-1:0] nabs;
   logic [RW-1:0] dabs;

   logic [RW-1:0]     rem_ff  [0:NS-1];
   logic [RW-1:0]     dabs_ff [0:NS-1];
   logic [ELEM_W-1:0] q_ff    [0:NS];
   logic              neg_ff  [0:NS];
   logic              ovf_ff  [0:NS];

   assign num_ext = RW'(num) <<< (2 * FRAC_BITS);
   assign den_ext = RW'(den);
   assign nabs = num_ext[RW-1] ? -num_ext : num_ext;
   assign dabs = den_ext[RW-1] ? -den_ext : den_ext;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= nabs;
         dabs_ff[0] <= dabs;
         q_ff[0]    <= '0;
         neg_ff[0]  <= num[COF_W-1] ^ den[DET_W-1];
         ovf_ff[0]  <= nabs >= (dabs << ELEM_W);
      end
   end

   for (genvar s = 1; s <= NS; s++) begin : g_step
      localparam int K = NS - s;
      logic [RW-1:0] trial;
      logic          take;

      assign trial = dabs_ff[s-1] << K;
      assign take  = rem_ff[s-1] >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[s]   <= take ? (q_ff[s-1] | (ELEM_W'(1) << K)) : q_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
         end
      end

      if (s < NS) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s]  <= take ? (rem_ff[s-1] - trial) : rem_ff[s-1];
               dabs_ff[s] <= dabs_ff[s-1];
            end
         end
      end
   end

   logic [ELEM_W:0] mag;
   logic [ELEM_W:0] nmag;

   assign mag  = {ovf_ff[NS], q_ff[NS]};
   assign nmag = -mag;

   always_comb begin
      if (!neg_ff[NS]) begin
         quot = (mag >= LIM) ? ELEM_MAX : elem_type'(mag[ELEM_W-1:0]);
      end else begin
         quot = (mag > LIM) ? ELEM_MIN : elem_type'(nmag[ELEM_W-1:0]);
      end
   end
endmodule

>>> rtl/m3i_merge.sv
// Merge stage: gathers the nine lane quotients, scales and saturates the
// determinant, handles the singular case and holds the output register.
`timescale 1ns / 1ps

module m3i_merge #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              valid,
   input  m3i_pkg::quot_vec_type             quot,
   input  logic signed [m3i_pkg::DET_W-1:0]  det,
   output logic                              rsp_valid,
   output m3i_pkg::rsp_type                  rsp_data
);
   import m3i_pkg::*;

   localparam int SW = DET_W - 2 * FRAC_BITS;

   logic signed [SW-1:0] dsh;
   logic signed [SW-1:0] dtr;
   logic                 fix;
   logic                 sing;
   elem_type             dval;
   rsp_type              rsp_in;

   assign dsh  = $signed(det[DET_W-1:2*FRAC_BITS]);
   assign fix  = det[DET_W-1] && (det[2*FRAC_BITS-1:0] != '0);
   assign dtr  = dsh + $signed({{(SW-1){1'b0}}, fix});
   assign sing = (det == '0);

   always_comb begin
      if (dtr > SW'(ELEM_MAX)) begin
         dval = ELEM_MAX;
      end else if (dtr < SW'(ELEM_MIN)) begin
         dval = ELEM_MIN;
      end else begin
         dval = elem_type'(dtr[ELEM_W-1:0]);
      end
   end

   always_comb begin
      rsp_in.inv00     = sing ? '0 : elem_type'(quot[0]);
      rsp_in.inv01     = sing ? '0 : elem_type'(quot[1]);
      rsp_in.inv02     = sing ? '0 : elem_type'(quot[2]);
      rsp_in.inv10     = sing ? '0 : elem_type'(quot[3]);
      rsp_in.inv11     = sing ? '0 : elem_type'(quot[4]);
      rsp_in.inv12     = sing ? '0 : elem_type'(quot[5]);
      rsp_in.inv20     = sing ? '0 : elem_type'(quot[6]);
      rsp_in.inv21     = sing ? '0 : elem_type'(quot[7]);
      rsp_in.inv22     = sing ? '0 : elem_type'(quot[8]);
      rsp_in.det_value = sing ? '0 : dval;
      rsp_in.singular  = sing;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (en) begin
         rsp_valid <= valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data <= rsp_in;
      end
   end
endmodule

>>> rtl/matrix3x3_inverse.sv
// Top level of the 3x3 matrix inverse: products, cofactors and determinant,
// then nine divider lanes in parallel and a merge stage. Uses m3i_pkg.
// The divider lanes retire one quotient bit per stage.
// Throughput is one request per cycle; the whole pipeline holds while a result stalls.
// Reset is synchronous, active high, and clears only the stage valid bits.
`timescale 1ns / 1ps
`include "matrix3x3_inverse_assert.svh"

module matrix3x3_inverse #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  m3i_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output m3i_pkg::rsp_type  rsp_data
);
   import m3i_pkg::*;

   localparam int LAT  = ELEM_W + 1;
   localparam int LO_W = 2 * ELEM_W + 1;
   localparam int HI_W = 2 * ELEM_W + 2;

   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic vd_ff [0:LAT-1];

   elem_type e_ff [3][3];
   elem_type a0_2_ff [3];
   elem_type a0_3_ff [3];
   logic signed [PROD_W-1:0] pa_ff [3][3];
   logic signed [PROD_W-1:0] pb_ff [3][3];
   logic signed [COF_W-1:0]  cof3_ff [3][3];
   logic signed [COF_W-1:0]  cof4_ff [3][3];
   logic signed [COF_W-1:0]  cof5_ff [3][3];
   logic signed [LO_W-1:0]   plo_ff [3];
   logic signed [HI_W-1:0]   phi_ff [3];
   logic signed [DET_W-1:0]  det_in;
   logic signed [DET_W-1:0]  det_ff;
   logic signed [DET_W-1:0]  detd_ff [0:LAT-1];
   quot_vec_type             quot;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff[0][0] <= req_data.a00;
         e_ff[0][1] <= req_data.a01;
         e_ff[0][2] <= req_data.a02;
         e_ff[1][0] <= req_data.a10;
         e_ff[1][1] <= req_data.a11;
         e_ff[1][2] <= req_data.a12;
         e_ff[2][0] <= req_data.a20;
         e_ff[2][1] <= req_data.a21;
         e_ff[2][2] <= req_data.a22;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_row
      localparam int R0 = (i == 0) ? 1 : 0;
      localparam int R1 = (i == 2) ? 1 : 2;
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int C0 = (j == 0) ? 1 : 0;
         localparam int C1 = (j == 2) ? 1 : 2;
         localparam bit FLIP = ((i + j) % 2) == 1;

         always_ff @(posedge clock) begin
            if (en) begin
               pa_ff[i][j] <= e_ff[R0][C0] * e_ff[R1][C1];
               pb_ff[i][j] <= e_ff[R0][C1] * e_ff[R1][C0];
               if (FLIP) begin
                  cof3_ff[i][j] <= COF_W'(pb_ff[i][j]) - COF_W'(pa_ff[i][j]);
               end else begin
                  cof3_ff[i][j] <= COF_W'(pa_ff[i][j]) - COF_W'(pb_ff[i][j]);
               end
               cof4_ff[i][j] <= cof3_ff[i][j];
               cof5_ff[i][j] <= cof4_ff[i][j];
            end
         end
      end
   end

   for (genvar j = 0; j < 3; j++) begin : g_det
      always_ff @(posedge clock) begin
         if (en) begin
            a0_2_ff[j] <= e_ff[0][j];
            a0_3_ff[j] <= a0_2_ff[j];
            plo_ff[j]  <= a0_3_ff[j] * $signed({1'b0, cof3_ff[0][j][ELEM_W-1:0]});
            phi_ff[j]  <= a0_3_ff[j] * $signed(cof3_ff[0][j][COF_W-1:ELEM_W]);
         end
      end
   end

   always_comb begin
      det_in = '0;
      for (int j = 0; j < 3; j++) begin
         det_in = det_in + (DET_W'(phi_ff[j]) <<< ELEM_W) + DET_W'(plo_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff <= det_in;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane_row
      for (genvar j = 0; j < 3; j++) begin : g_lane_col
         elem_type q;
         m3i_div_lane #(
            .FRAC_BITS(FRAC_BITS)
         ) u_lane (
            .clock(clock),
            .en   (en),
            .num  (cof5_ff[j][i]),
            .den  (det_ff),
            .quot (q)
         );
         assign quot[i*3+j] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            vd_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vd_ff[0] <= v5_ff;
         for (int k = 1; k < LAT; k++) begin
            vd_ff[k] <= vd_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         detd_ff[0] <= det_ff;
         for (int k = 1; k < LAT; k++) begin
            detd_ff[k] <= detd_ff[k-1];
         end
      end
   end

   m3i_merge #(
      .FRAC_BITS(FRAC_BITS)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .valid    (vd_ff[LAT-1]),
      .quot     (quot),
      .det      (detd_ff[LAT-1]),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   `M3I_ASSERT_NEXT(a_accept_enters, req_valid && !req_stall, v1_ff)
   `M3I_ASSERT_NEXT(a_stall_holds_pipe, rsp_valid && rsp_stall, $stable(v5_ff) && $stable(det_ff))
   `M3I_ASSERT_IMPL(a_singular_zero, rsp_valid && rsp_data.singular, (rsp_data >> 1) == '0)
endmodule

>>> sim/matrix3x3_inverse_tb.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse block.
// Depends on m3i_pkg and matrix3x3_inverse; predicts each result with exact wide arithmetic.
`timescale 1ns / 1ps

module matrix3x3_inverse_tb;
   import m3i_pkg::*;

   localparam int FRAC = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam elem_type ONE = 32'sd65536;

   typedef struct {
      req_type mat;
      bit      drain;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b1;
   rsp_type rsp_data;

   pending_type pending_q[$];
   rsp_type     inverse_q[$];
   int          gap_left = 0;
   int          sent_count = 0;
   int          got_count = 0;
   int          stall_left = 0;
   bit          long_hold_done = 1'b0;
   int          mismatch_count = 0;
   int          cycle_count = 0;

   matrix3x3_inverse dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   function automatic elem_type saturate(logic signed [255:0] v);
      if (v > $signed(256'(ELEM_MAX))) return ELEM_MAX;
      if (v < -$signed(256'sd2147483648)) return ELEM_MIN;
      return elem_type'(v[31:0]);
   endfunction

   function automatic rsp_type invert_matrix(req_type m);
      logic signed [255:0] e[3][3];
      logic signed [255:0] cof[3][3];
      logic signed [255:0] det;
      logic signed [255:0] minor;
      elem_type            inv[3][3];
      rsp_type             r;
      int                  r0, r1, c0, c1;
      e[0][0] = m.a00; e[0][1] = m.a01; e[0][2] = m.a02;
      e[1][0] = m.a10; e[1][1] = m.a11; e[1][2] = m.a12;
      e[2][0] = m.a20; e[2][1] = m.a21; e[2][2] = m.a22;
      for (int i = 0; i < 3; i++) begin
         r0 = (i == 0) ? 1 : 0;
         r1 = (i == 2) ? 1 : 2;
         for (int j = 0; j < 3; j++) begin
            c0 = (j == 0) ? 1 : 0;
            c1 = (j == 2) ? 1 : 2;
            minor = e[r0][c0] * e[r1][c1] - e[r0][c1] * e[r1][c0];
            cof[i][j] = ((i + j) % 2 == 1) ? -minor : minor;
         end
      end
      det = e[0][0] * cof[0][0] + e[0][1] * cof[0][1] + e[0][2] * cof[0][2];
      r = '0;
      if (det == 0) begin
         r.singular = 1'b1;
         return r;
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            inv[i][j] = saturate((cof[j][i] <<< (2 * FRAC)) / det);
      r.inv00 = inv[0][0]; r.inv01 = inv[0][1]; r.inv02 = inv[0][2];
      r.inv10 = inv[1][0]; r.inv11 = inv[1][1]; r.inv12 = inv[1][2];
      r.inv20 = inv[2][0]; r.inv21 = inv[2][1]; r.inv22 = inv[2][2];
      r.det_value = saturate(det / (256'sd1 <<< (2 * FRAC)));
      return r;
   endfunction

   function automatic elem_type rand_elem(int span);
      return elem_type'($urandom_range(0, 2 * span)) - elem_type'(span);
   endfunction

   function automatic elem_type rand_extreme();
      case ($urandom_range(0, 5))
         0: return ELEM_MAX;
         1: return ELEM_MIN;
         2: return '0;
         3: return ONE;
         4: return -ONE;
         default: return elem_type'($urandom);
      endcase
   endfunction

   function automatic req_type make_matrix(elem_type v00, elem_type v01, elem_type v02,
                                           elem_type v10, elem_type v11, elem_type v12,
                                           elem_type v20, elem_type v21, elem_type v22);
      req_type m;
      m.a00 = v00; m.a01 = v01; m.a02 = v02;
      m.a10 = v10; m.a11 = v11; m.a12 = v12;
      m.a20 = v20; m.a21 = v21; m.a22 = v22;
      return m;
   endfunction

   function automatic req_type random_matrix();
      req_type  m;
      elem_type f[9];
      int       kind, span;
      kind = $urandom_range(0, 99);
      span = ($urandom_range(0, 1) == 1) ? 262144 : 16384;
      for (int k = 0; k < 9; k++) begin
         if (kind < 50) f[k] = rand_elem(span);
         else if (kind < 65) f[k] = elem_type'($urandom);
         else if (kind < 75) f[k] = rand_elem(8);
         else f[k] = rand_extreme();
      end
      if (kind >= 85) begin
         case ($urandom_range(0, 2))
            0: for (int k = 0; k < 3; k++) f[6 + k] = f[k];
            1: for (int k = 0; k < 3; k++) f[3 * k + 2] = f[3 * k];
            default: for (int k = 0; k < 3; k++) f[3 + k] = '0;
         endcase
      end
      m = make_matrix(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8]);
      return m;
   endfunction

   task automatic add_request(req_type m, bit drain);
      pending_type p;
      p.mat = m;
      p.drain = drain;
      pending_q.push_back(p);
   endtask

   task automatic check_field(string name, elem_type want, elem_type got, inout bit bad);
      if (want !== got) begin
         bad = 1'b1;
         if (mismatch_count < 10)
            $display("%s mismatch: expected %h, actual %h", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            inverse_q.push_back(invert_matrix(req_data));
            sent_count++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (pending_q.size() > 0 &&
                         !(pending_q[0].drain && (inverse_q.size() > 0 || req_valid))) begin
               req_valid <= 1'b1;
               req_data <= pending_q.pop_front().mat;
               if (sent_count % 200 < 50) gap_left <= 0;
               else if ($urandom_range(0, 99) < 60) gap_left <= 0;
               else if ($urandom_range(0, 99) < 85) gap_left <= $urandom_range(1, 3);
               else gap_left <= $urandom_range(10, 40);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!long_hold_done && got_count >= 300) begin
         rsp_stall <= 1'b1;
         stall_left <= 300;
         long_hold_done <= 1'b1;
      end else if (got_count % 250 < 60 || $urandom_range(0, 99) < 70) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b1;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                   : $urandom_range(0, 3);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      bit      bad;
      if (!reset && rsp_valid && !rsp_stall) begin
         got_count++;
         if (inverse_q.size() == 0) begin
            if (mismatch_count < 10) $display("unexpected result %h", rsp_data);
            mismatch_count++;
         end else begin
            want = inverse_q.pop_front();
            bad = 1'b0;
            check_field("inv00", want.inv00, rsp_data.inv00, bad);
            check_field("inv01", want.inv01, rsp_data.inv01, bad);
            check_field("inv02", want.inv02, rsp_data.inv02, bad);
            check_field("inv10", want.inv10, rsp_data.inv10, bad);
            check_field("inv11", want.inv11, rsp_data.inv11, bad);
            check_field("inv12", want.inv12, rsp_data.inv12, bad);
            check_field("inv20", want.inv20, rsp_data.inv20, bad);
            check_field("inv21", want.inv21, rsp_data.inv21, bad);
            check_field("inv22", want.inv22, rsp_data.inv22, bad);
            check_field("det_value", want.det_value, rsp_data.det_value, bad);
            if (want.singular !== rsp_data.singular) begin
               bad = 1'b1;
               if (mismatch_count < 10)
                  $display("singular mismatch: expected %b, actual %b",
                           want.singular, rsp_data.singular);
            end
            if (bad) mismatch_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      add_request(make_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1'b0);
      add_request(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
      add_request(make_matrix(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX,
                              ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX), 1'b0);
      add_request(make_matrix(ELEM_MAX, 0, 0, 0, ELEM_MAX, 0, 0, 0, ELEM_MAX), 1'b0);
      add_request(make_matrix(ELEM_MIN, 0, 0, 0, ELEM_MIN, 0, 0, 0, ELEM_MIN), 1'b0);
      add_request(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1), 1'b0);
      add_request(make_matrix(-1, 0, 0, 0, 1, 0, 0, 0, 1), 1'b0);
      add_request(make_matrix(0, ONE, 0, 0, 0, ONE, ONE, 0, 0), 1'b0);
      add_request(make_matrix(-2 * ONE, 0, 0, 0, ONE / 2, 0, 0, 0, 4 * ONE), 1'b0);
      add_request(make_matrix(ELEM_MAX, ELEM_MIN, 0, ELEM_MIN, ELEM_MAX, ELEM_MIN,
                              0, ELEM_MIN, ELEM_MAX), 1'b0);
      add_request(make_matrix(ELEM_MIN, ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MIN,
                              ELEM_MAX, ELEM_MIN, ELEM_MAX, -1), 1'b0);
      add_request(make_matrix(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                              7 * ONE, 8 * ONE, 9 * ONE), 1'b0);
      add_request(make_matrix(2 * ONE, ONE, 0, ONE, 3 * ONE, ONE, 0, ONE, 4 * ONE), 1'b0);
      add_request(make_matrix(-1, -1, -1, -1, -1, -1, -1, -1, -1), 1'b0);
      add_request(make_matrix(ELEM_MAX, 1, 0, 0, 1, 0, 0, 0, 1), 1'b0);
      add_request(make_matrix(1000 * ONE, 0, 0, 0, 1000 * ONE, 0, 0, 0, 1000 * ONE), 1'b0);
      for (int n = 0; n < 850; n++)
         add_request(random_matrix(), (n == 400 || n == 700));
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0);
      @(posedge clock);
      while (req_valid || inverse_q.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && inverse_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/m3i_pkg.sv
rtl/m3i_div_lane.sv
rtl/m3i_merge.sv
rtl/matrix3x3_inverse.sv
sim/matrix3x3_inverse_tb.sv
